>>> src/heightfield_terrain_mesher_core_defines.svh
// Assertion macros for the port checker of the terrain mesher.
// Stands alone; the checker file pulls it in by include.
`ifndef HEIGHTFIELD_TERRAIN_MESHER_CORE_DEFINES_SVH
`define HEIGHTFIELD_TERRAIN_MESHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HTM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("htm port check failed");

// Next-cycle implication, checked outside reset.
`define HTM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("htm port check failed");

`endif

>>> src/htm_pkg.sv
// Shared types and constants of the terrain mesher.
// No dependencies; every other file but the macro header imports it.
`default_nettype none

package htm_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;

  localparam logic [CFG_IW-1:0] CFG_GRID_SIZE      = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_DELTA     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_EDGE_SCALE     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INTERIOR_SCALE = 3'd3;

  localparam logic [8:0]  GRID_SIZE_RST      = 9'd64;
  localparam logic [15:0] GRID_DELTA_RST     = 16'd1024;
  localparam logic [15:0] EDGE_SCALE_RST     = 16'd4096;
  localparam logic [16:0] INTERIOR_SCALE_RST = 17'd2048;

  localparam logic [16:0] COORD_MAX = 17'h1FFFF;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    KIND_CORNER,
    KIND_ROW0,
    KIND_COL0,
    KIND_INNER
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t kind;
    logic       last;
  } cell_meta_t;

  typedef struct packed {
    logic [16:0]        v0_x;
    logic signed [31:0] v0_y;
    logic [16:0]        v0_z;
    logic [16:0]        v1_x;
    logic signed [31:0] v1_y;
    logic [16:0]        v1_z;
    logic [16:0]        v2_x;
    logic signed [31:0] v2_y;
    logic [16:0]        v2_z;
    logic               last_of_pair;
    logic               mesh_done;
  } tri_word_t;

endpackage

`default_nettype wire

>>> src/htm_front.sv
// Front end: takes noise words, tracks the raster position and classifies each cell.
// Depends on htm_pkg.
`default_nettype none

module htm_front import htm_pkg::*; #(
  parameter int MAX_GRID = 256,
  localparam int IW = $clog2(MAX_GRID)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [8:0]         grid_size,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] noise_sample,
  output logic                    in_stall,
  input  wire logic               q_full,
  output logic                    push,
  output logic [IW-1:0]           push_r,
  output logic [IW-1:0]           push_c,
  output logic signed [15:0]      push_noise,
  output cell_meta_t              push_meta
);

  localparam int SW = (IW + 1 > 9) ? IW + 1 : 9;
  localparam logic [SW-1:0] MAXN = SW'(MAX_GRID);

  logic [IW-1:0] row, col, row_next, col_next;
  logic [SW-1:0] gs, n, c1, r1, r_w, cn, rn;

  assign in_stall   = q_full;
  assign push       = in_valid && !q_full;
  assign push_noise = noise_sample;

  always_comb begin
    gs = SW'(grid_size);
    if (gs < SW'(2)) n = SW'(2);
    else if (gs > MAXN) n = MAXN;
    else n = gs;

    // A shrunken grid can leave the stored position outside; wrap it first.
    if (SW'(col) >= n) begin
      c1 = '0;
      r1 = SW'(row) + SW'(1);
    end else begin
      c1 = SW'(col);
      r1 = SW'(row);
    end
    r_w = (r1 >= n) ? '0 : r1;

    cn = c1 + SW'(1);
    rn = r_w + SW'(1);
    if (cn >= n) begin
      col_next = '0;
      row_next = (rn >= n) ? '0 : rn[IW-1:0];
    end else begin
      col_next = cn[IW-1:0];
      row_next = r_w[IW-1:0];
    end

    push_r = r_w[IW-1:0];
    push_c = c1[IW-1:0];
    if (r_w == '0 && c1 == '0) push_meta.kind = KIND_CORNER;
    else if (r_w == '0) push_meta.kind = KIND_ROW0;
    else if (c1 == '0) push_meta.kind = KIND_COL0;
    else push_meta.kind = KIND_INNER;
    push_meta.last = (r_w == n - SW'(1)) && (c1 == n - SW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (push) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

`default_nettype wire

>>> src/htm_queue.sv
// Short FIFO that decouples the front end from the height pipeline.
// Depends on htm_pkg for its depth.
`default_nettype none

module htm_queue import htm_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              valid
);

  logic [W-1:0]   slots [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;
  logic           do_push, do_pop;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign valid   = (count != '0);
  assign rdata   = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + QAW'(1);
      if (do_pop) rptr <= rptr + QAW'(1);
      if (do_push && !do_pop) count <= count + (QAW+1)'(1);
      else if (do_pop && !do_push) count <= count - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= wdata;
  end

endmodule

`default_nettype wire

>>> src/htm_back.sv
// Height pipeline: gain multiply and row-store read, then height update and
// triangle assembly into a two-word output buffer. Depends on htm_pkg.
`default_nettype none

module htm_back import htm_pkg::*; #(
  parameter int MAX_GRID = 256,
  localparam int IW = $clog2(MAX_GRID)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        grid_delta,
  input  wire logic [15:0]        edge_scale,
  input  wire logic [16:0]        interior_scale,
  input  wire logic               q_valid,
  input  wire logic [IW-1:0]      q_r,
  input  wire logic [IW-1:0]      q_c,
  input  wire logic signed [15:0] q_noise,
  input  wire cell_meta_t         q_meta,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tri_word_t               out_word
);

  localparam int PW = IW + 16;
  localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

  function automatic logic [16:0] coord(input logic [IW-1:0] idx, input logic [15:0] d);
    logic [PW-1:0] p;
    p = PW'(idx) * PW'(d);
    return (p > PW'(COORD_MAX)) ? COORD_MAX : p[16:0];
  endfunction

  logic signed [31:0] row_mem [MAX_GRID];

  // Stage 1: product and row-store read.
  logic               s1_valid, s1_load, s1_adv;
  logic [IW-1:0]      s1_c;
  logic signed [15:0] s1_noise;
  cell_meta_t         s1_meta;
  logic signed [33:0] s1_prod;
  logic [16:0]        s1_x_lo, s1_x_hi, s1_z_lo, s1_z_hi;
  logic signed [31:0] rd_data, byp_data;
  logic               byp;

  // Stage 2: height update.
  logic               s2_valid, fire, load_pair, take;
  logic [IW-1:0]      s2_c;
  logic signed [15:0] s2_noise;
  cell_meta_t         s2_meta;
  logic signed [33:0] s2_prod;
  logic [16:0]        s2_x_lo, s2_x_hi, s2_z_lo, s2_z_hi;
  logic signed [31:0] s2_up;

  logic signed [31:0] left, diag, h;
  logic [1:0]         cnt;
  tri_word_t          pend, w0, w1;

  logic [16:0]        gain;
  logic signed [33:0] prod_in, g_full, base, sum;
  logic signed [31:0] up_in;

  assign out_valid = (cnt != 2'd0);
  assign take      = out_valid && !out_stall;
  // An inner cell needs both buffer slots; edge cells only update state.
  assign fire      = s2_valid && (s2_meta.kind != KIND_INNER || cnt == 2'd0 ||
                                  (cnt == 2'd1 && take));
  assign load_pair = fire && (s2_meta.kind == KIND_INNER);
  assign s1_adv    = s1_valid && (!s2_valid || fire);
  assign s1_load   = q_valid && (!s1_valid || s1_adv);
  assign q_pop     = s1_load;

  always_comb begin
    gain    = (q_meta.kind == KIND_INNER) ? interior_scale : {1'b0, edge_scale};
    prod_in = 34'(q_noise) * 34'($signed({1'b0, gain}));
    if (s1_meta.kind == KIND_CORNER || s1_meta.kind == KIND_ROW0) up_in = '0;
    else up_in = byp ? byp_data : rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv) s2_valid <= 1'b1;
      else if (fire) s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_c     <= q_c;
      s1_noise <= q_noise;
      s1_meta  <= q_meta;
      s1_prod  <= prod_in;
      s1_x_lo  <= coord(q_c - IW'(1), grid_delta);
      s1_x_hi  <= coord(q_c, grid_delta);
      s1_z_lo  <= coord(q_r - IW'(1), grid_delta);
      s1_z_hi  <= coord(q_r, grid_delta);
      // With a two-wide grid the cell being written now is the one read here.
      byp      <= fire && (s2_c == q_c);
      byp_data <= h;
    end
    if (s1_adv) begin
      s2_c     <= s1_c;
      s2_noise <= s1_noise;
      s2_meta  <= s1_meta;
      s2_prod  <= s1_prod;
      s2_x_lo  <= s1_x_lo;
      s2_x_hi  <= s1_x_hi;
      s2_z_lo  <= s1_z_lo;
      s2_z_hi  <= s1_z_hi;
      s2_up    <= up_in;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) row_mem[s2_c] <= h;
    if (s1_load) rd_data <= row_mem[q_c];
  end

  always_comb begin
    g_full = (s2_prod + 34'sd2048) >>> 12;
    case (s2_meta.kind)
      KIND_ROW0:  base = 34'(left);
      KIND_COL0:  base = 34'(s2_up);
      KIND_INNER: base = (34'(left) + 34'(s2_up)) >>> 1;
      default:    base = '0;
    endcase
    sum = base + g_full;
    if (s2_meta.kind == KIND_CORNER) h = {{12{s2_noise[15]}}, s2_noise, 4'b0000};
    else if (sum > SAT_HI) h = SAT_HI[31:0];
    else if (sum < SAT_LO) h = SAT_LO[31:0];
    else h = sum[31:0];

    w0.v0_x = s2_x_lo;  w0.v0_y = diag;   w0.v0_z = s2_z_lo;
    w0.v1_x = s2_x_lo;  w0.v1_y = left;   w0.v1_z = s2_z_hi;
    w0.v2_x = s2_x_hi;  w0.v2_y = h;      w0.v2_z = s2_z_hi;
    w0.last_of_pair = 1'b0;
    w0.mesh_done    = 1'b0;

    w1.v0_x = s2_x_hi;  w1.v0_y = h;      w1.v0_z = s2_z_hi;
    w1.v1_x = s2_x_hi;  w1.v1_y = s2_up;  w1.v1_z = s2_z_lo;
    w1.v2_x = s2_x_lo;  w1.v2_y = diag;   w1.v2_z = s2_z_lo;
    w1.last_of_pair = 1'b1;
    w1.mesh_done    = s2_meta.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      diag <= '0;
      cnt  <= 2'd0;
    end else begin
      if (fire) begin
        left <= h;
        diag <= s2_up;
      end
      if (load_pair) cnt <= 2'd2;
      else if (take) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pair) begin
      out_word <= w0;
      pend     <= w1;
    end else if (take && cnt == 2'd2) begin
      out_word <= pend;
    end
  end

endmodule

`default_nettype wire

>>> src/heightfield_terrain_mesher_core.sv
// Top level of the height-field terrain mesher: configuration registers,
// front end, decoupling queue and height pipeline. Depends on htm_pkg.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid / in_stall    | noise_sample
//   out     | output    | out_valid / out_stall  | three vertices, pair and done flags
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An edge cell puts out no word; an inner cell puts out two triangle words, one after
// the other on the single output port. A noise word accepted at the input passes the
// queue, the multiply and row-store read, the height update and the output register
// before its first triangle reaches the outputs. Reset is synchronous and clears
// position, heights and all valid state; the row store is not cleared. Output stall
// backs up through the pipeline into the queue, and in_stall rises only when the
// four-word queue is full.
`default_nettype none

module heightfield_terrain_mesher_core import htm_pkg::*; #(
  parameter int MAX_GRID = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [CFG_DW-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] noise_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             v0_x,
  output logic signed [31:0]      v0_y,
  output logic [16:0]             v0_z,
  output logic [16:0]             v1_x,
  output logic signed [31:0]      v1_y,
  output logic [16:0]             v1_z,
  output logic [16:0]             v2_x,
  output logic signed [31:0]      v2_y,
  output logic [16:0]             v2_z,
  output logic                    last_of_pair,
  output logic                    mesh_done
);

  localparam int IW = $clog2(MAX_GRID);
  localparam int QW = $bits(cell_meta_t) + 16 + 2 * IW;

  logic [8:0]  grid_size;
  logic [15:0] grid_delta;
  logic [15:0] edge_scale;
  logic [16:0] interior_scale;

  logic               q_full, push, q_valid, q_pop;
  logic [IW-1:0]      push_r, push_c, q_r, q_c;
  logic signed [15:0] push_noise, q_noise;
  cell_meta_t         push_meta, q_meta;
  logic [QW-1:0]      q_wdata, q_rdata;
  tri_word_t          out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size      <= GRID_SIZE_RST;
      grid_delta     <= GRID_DELTA_RST;
      edge_scale     <= EDGE_SCALE_RST;
      interior_scale <= INTERIOR_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_SIZE:      grid_size      <= cfg_data[8:0];
        CFG_GRID_DELTA:     grid_delta     <= cfg_data[15:0];
        CFG_EDGE_SCALE:     edge_scale     <= cfg_data[15:0];
        CFG_INTERIOR_SCALE: interior_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  htm_front #(.MAX_GRID(MAX_GRID)) u_front (
    .clk          (clk),
    .rst          (rst),
    .grid_size    (grid_size),
    .in_valid     (in_valid),
    .noise_sample (noise_sample),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .push         (push),
    .push_r       (push_r),
    .push_c       (push_c),
    .push_noise   (push_noise),
    .push_meta    (push_meta)
  );

  assign q_wdata = {push_meta, push_noise, push_r, push_c};
  assign {q_meta, q_noise, q_r, q_c} = q_rdata;

  htm_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  htm_back #(.MAX_GRID(MAX_GRID)) u_back (
    .clk            (clk),
    .rst            (rst),
    .grid_delta     (grid_delta),
    .edge_scale     (edge_scale),
    .interior_scale (interior_scale),
    .q_valid        (q_valid),
    .q_r            (q_r),
    .q_c            (q_c),
    .q_noise        (q_noise),
    .q_meta         (q_meta),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

  assign v0_x         = out_word.v0_x;
  assign v0_y         = out_word.v0_y;
  assign v0_z         = out_word.v0_z;
  assign v1_x         = out_word.v1_x;
  assign v1_y         = out_word.v1_y;
  assign v1_z         = out_word.v1_z;
  assign v2_x         = out_word.v2_x;
  assign v2_y         = out_word.v2_y;
  assign v2_z         = out_word.v2_z;
  assign last_of_pair = out_word.last_of_pair;
  assign mesh_done    = out_word.mesh_done;

endmodule

`default_nettype wire

>>> src/htm_chk.sv
// Port-level checker for the terrain mesher, bound to the top level.
// Depends on htm_pkg and the shared assertion macro header.
`default_nettype none
`include "heightfield_terrain_mesher_core_defines.svh"

module htm_chk import htm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [CFG_IW-1:0]  cfg_index,
  input wire logic [CFG_DW-1:0]  cfg_data,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic signed [15:0] noise_sample,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [16:0]        v0_x,
  input wire logic signed [31:0] v0_y,
  input wire logic [16:0]        v0_z,
  input wire logic [16:0]        v1_x,
  input wire logic signed [31:0] v1_y,
  input wire logic [16:0]        v1_z,
  input wire logic [16:0]        v2_x,
  input wire logic signed [31:0] v2_y,
  input wire logic [16:0]        v2_z,
  input wire logic               last_of_pair,
  input wire logic               mesh_done
);

  // A stalled output word stays put.
  `HTM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(v0_y) && $stable(v2_y) && $stable(last_of_pair))

  // Only the second triangle of a quad can close the mesh.
  `HTM_ASSERT_IMP(a_done_on_second, clk, rst, out_valid && mesh_done, last_of_pair)

  // The second triangle follows at once and starts where the first one ended.
  `HTM_ASSERT_NXT(a_pair_follows, clk, rst, out_valid && !out_stall && !last_of_pair, out_valid && last_of_pair && v0_x == $past(v2_x) && v0_z == $past(v2_z) && v0_y == $past(v2_y))

  // Both triangles share a column between their first two vertices.
  `HTM_ASSERT_IMP(a_shared_column, clk, rst, out_valid, v1_x == (last_of_pair ? v0_x : v0_x) && (last_of_pair || v2_z == v1_z))

endmodule

bind heightfield_terrain_mesher_core htm_chk u_htm_chk (.*);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking bench for heightfield_terrain_mesher_core. It predicts every
// triangle word from the noise words it sends and compares field by field.
// Needs htm_pkg and the mesher RTL only.
`timescale 1ns / 1ps

module testbench;
  import htm_pkg::*;

  localparam int MAX_GRID = 256;
  localparam int ITEM_TARGET = 1250;
  localparam int SETTLE_CYCLES = 24;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IW-1:0] CFG_NO_REG_LO = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_NO_REG_HI = 3'd7;

  typedef logic [31:0] tri_fields_t [11];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] noise_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] v0_x, v0_z, v1_x, v1_z, v2_x, v2_z;
  logic signed [31:0] v0_y, v1_y, v2_y;
  logic last_of_pair, mesh_done;

  // Predictor copy of the registers and of the height state.
  logic [8:0] cfg_grid_size = GRID_SIZE_RST;
  logic [15:0] cfg_grid_delta = GRID_DELTA_RST;
  logic [15:0] cfg_edge_scale = EDGE_SCALE_RST;
  logic [16:0] cfg_interior_scale = INTERIOR_SCALE_RST;
  logic signed [31:0] row_heights [MAX_GRID];
  bit row_written [MAX_GRID];
  logic signed [31:0] left_h = '0;
  logic signed [31:0] diag_h = '0;
  int cur_row = 0;
  int cur_col = 0;

  tri_word_t expected_tris [$];
  string field_name [11] = '{"v0_x", "v0_y", "v0_z", "v1_x", "v1_y", "v1_z",
                             "v2_x", "v2_y", "v2_z", "last_of_pair", "mesh_done"};

  bit calm = 1'b0;
  int mismatches = 0;
  int samples_sent = 0;
  int config_writes = 0;
  int triangles_checked = 0;
  int meshes_closed = 0;

  heightfield_terrain_mesher_core #(.MAX_GRID(MAX_GRID)) i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int grid_points(input logic [8:0] size_field);
    if (size_field < 2) return 2;
    if (size_field > MAX_GRID) return MAX_GRID;
    return int'(size_field);
  endfunction

  function automatic logic [16:0] grid_coord(input int idx);
    longint p;
    p = longint'(idx) * longint'(cfg_grid_delta);
    if (p > COORD_MAX) return COORD_MAX;
    return p[16:0];
  endfunction

  // Q4.12 noise times a Q.16 gain, rounded half up back to Q16.16.
  function automatic longint scaled_noise(input longint nz, input longint gain);
    return (nz * gain + 2048) >>> 12;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic tri_word_t make_tri(input int xa, za, input logic signed [31:0] ha,
                                         input int xb, zb, input logic signed [31:0] hb,
                                         input int xc, zc, input logic signed [31:0] hc,
                                         input logic pair_end, grid_end);
    tri_word_t t;
    t.v0_x = grid_coord(xa);
    t.v0_y = ha;
    t.v0_z = grid_coord(za);
    t.v1_x = grid_coord(xb);
    t.v1_y = hb;
    t.v1_z = grid_coord(zb);
    t.v2_x = grid_coord(xc);
    t.v2_y = hc;
    t.v2_z = grid_coord(zc);
    t.last_of_pair = pair_end;
    t.mesh_done = grid_end;
    return t;
  endfunction

  function automatic void queue_expected(input tri_word_t t);
    expected_tris.insert(expected_tris.size(), t);
  endfunction

  task automatic mesh_cell(input logic signed [15:0] noise);
    int n, r, c, i, j;
    longint nz;
    logic signed [31:0] h, up, diag;
    n = grid_points(cfg_grid_size);
    // The position is folded into the grid lazily, so a shrunken size acts here.
    if (cur_col >= n) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= n) cur_row = 0;
    r = cur_row;
    c = cur_col;
    nz = longint'(noise);
    diag = diag_h;
    up = (r > 0) ? row_heights[c] : 32'sd0;
    if (r == 0 && c == 0) begin
      h = 32'(nz * 16);
    end else if (r == 0) begin
      h = clip32(longint'(left_h) + scaled_noise(nz, cfg_edge_scale));
    end else if (c == 0) begin
      h = clip32(longint'(up) + scaled_noise(nz, cfg_edge_scale));
    end else begin
      h = clip32(((longint'(left_h) + longint'(up)) >>> 1)
                 + scaled_noise(nz, cfg_interior_scale));
    end
    if (r > 0 && c > 0) begin
      i = r - 1;
      j = c - 1;
      queue_expected(make_tri(j, i, diag, j, i + 1, left_h, j + 1, i + 1, h,
                              1'b0, 1'b0));
      queue_expected(make_tri(j + 1, i + 1, h, j + 1, i, up, j, i, diag,
                              1'b1, (r == n - 1) && (c == n - 1)));
    end
    diag_h = up;
    row_heights[c] = h;
    row_written[c] = 1'b1;
    left_h = h;
    cur_col = c + 1;
    if (cur_col >= n) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= n) cur_row = 0;
    end
  endtask

  // A size change must never make the block read a row-store entry that was
  // never written, which only a growing grid in the middle of a mesh can do.
  function automatic bit grow_is_safe(input int n_new);
    if (cur_row == 0) return 1'b1;
    for (int k = 0; k < n_new; k++) begin
      if (!row_written[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ----------------------------------------------------------------- drivers

  function automatic logic signed [15:0] random_noise();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic send_sample(input logic signed [15:0] value);
    if (!calm && $urandom_range(99) < 12) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 0)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    noise_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mesh_cell(value);
    samples_sent++;
  endtask

  task automatic finish_grid();
    while (cur_row != 0 || cur_col != 0) send_sample(random_noise());
  endtask

  // Edge cells leave no triangle behind, so the block may still be busy with
  // them when the last expected word has come; give it time to drain.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tris.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IW-1:0] index, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_GRID_SIZE: cfg_grid_size = data[8:0];
      CFG_GRID_DELTA: cfg_grid_delta = data[15:0];
      CFG_EDGE_SCALE: cfg_edge_scale = data[15:0];
      CFG_INTERIOR_SCALE: cfg_interior_scale = data[16:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [16:0] size_word, delta_word, edge_word, interior_word);
    if (!grow_is_safe(grid_points(size_word[8:0]))) begin
      // Drop to the smallest grid and close it, which always lands on row zero.
      settle();
      write_register(CFG_GRID_SIZE, 17'd2);
      finish_grid();
    end
    settle();
    write_register(CFG_GRID_SIZE, size_word);
    write_register(CFG_GRID_DELTA, delta_word);
    write_register(CFG_EDGE_SCALE, edge_word);
    write_register(CFG_INTERIOR_SCALE, interior_word);
  endtask

  // ------------------------------------------------------------ result side

  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 12);
  end

  function automatic tri_fields_t field_values(input tri_word_t t);
    return '{32'(t.v0_x), 32'(t.v0_y), 32'(t.v0_z), 32'(t.v1_x), 32'(t.v1_y), 32'(t.v1_z),
             32'(t.v2_x), 32'(t.v2_y), 32'(t.v2_z), 32'(t.last_of_pair), 32'(t.mesh_done)};
  endfunction

  always @(posedge clk) begin : check_words
    tri_word_t seen, want;
    tri_fields_t got_f, want_f;
    if (!rst && out_valid && !out_stall) begin
      seen = {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, last_of_pair, mesh_done};
      if (seen.mesh_done) meshes_closed++;
      if (expected_tris.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: triangle word arrived with none expected", $realtime);
      end else begin
        want = expected_tris.pop_front();
        got_f = field_values(seen);
        want_f = field_values(want);
        for (int k = 0; k < 11; k++) begin
          if (got_f[k] !== want_f[k]) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: triangle %0d field %s expected %h, got %h", $realtime,
                       triangles_checked, field_name[k], want_f[k], got_f[k]);
          end
        end
      end
      triangles_checked++;
    end
  end

  // ------------------------------------------------------------------ tests

  task automatic test_power_on_defaults();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
  endtask

  // The column left over from the 64-point grid lies past the new size.
  task automatic test_column_past_size();
    configure(17'd2, 17'h0FFFF, 17'h0FFFF, 17'h1FFFF);
    send_sample(16'shFFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
  endtask

  // Writes beyond the four registers must leave every setting unchanged.
  task automatic test_ignored_register();
    settle();
    write_register(CFG_NO_REG_LO, 17'h00005);
    write_register(CFG_NO_REG_HI, 17'h00000);
    send_sample(16'sh0800);
    send_sample(16'shF800);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
  endtask

  task automatic test_coordinate_clamp();
    configure(17'h00004, 17'h0FFFF, 17'h00000, 17'h10000);
    for (int k = 0; k < 8; k++) send_sample(k[0] ? 16'sh8000 : 16'sh7FFF);
  endtask

  // A zero size clamps to two, and the current row then lies past the grid.
  task automatic test_row_past_size();
    configure(17'h1FE00, 17'h08000, 17'h08000, 17'h00000);
    repeat (4) send_sample(random_noise());
  endtask

  task automatic test_random_grids(input int item_goal);
    logic [8:0] size9;
    logic [15:0] delta16, edge16;
    logic [16:0] interior17;
    int pick, n, count;
    while (samples_sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 8) size9 = 9'($urandom_range(1, 0));
      else if (pick < 20) size9 = 9'($urandom_range(40, 13));
      else size9 = 9'($urandom_range(12, 2));
      case ($urandom_range(3))
        0: delta16 = 16'h0000;
        1: delta16 = 16'hFFFF;
        2: delta16 = 16'h8000;
        default: delta16 = 16'($urandom);
      endcase
      case ($urandom_range(2))
        0: edge16 = 16'h0000;
        1: edge16 = 16'hFFFF;
        default: edge16 = 16'($urandom);
      endcase
      case ($urandom_range(3))
        0: interior17 = 17'h00000;
        1: interior17 = 17'h10000;
        2: interior17 = 17'h1FFFF;
        default: interior17 = 17'($urandom);
      endcase
      // Bits above each register's width ride along at random.
      configure({8'($urandom), size9}, {1'($urandom), delta16}, {1'($urandom), edge16},
                interior17);
      n = grid_points(size9);
      if (n <= 12 && $urandom_range(99) < 70) begin
        finish_grid();
        count = n * n;
      end else begin
        count = $urandom_range(80, 5);
      end
      repeat (count) send_sample(random_noise());
    end
  endtask

  // Largest grid, one full row and part of the next, with no idling on either side.
  task automatic test_full_size_no_idle();
    configure(17'd2, 17'd512, 17'h01000, 17'h00800);
    finish_grid();
    calm = 1'b1;
    configure(17'h001FF, 17'd512, 17'($urandom_range(65535)), 17'($urandom_range(131071)));
    repeat (300) send_sample(random_noise());
    settle();
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_on_defaults();
    test_column_past_size();
    test_ignored_register();
    test_coordinate_clamp();
    test_row_past_size();
    test_random_grids(700);
    test_full_size_no_idle();
    test_random_grids(ITEM_TARGET);
    settle();

    $display("Sent %0d noise words and made %0d register writes across grid sizes 2 to %0d.",
             samples_sent, config_writes, MAX_GRID);
    $display("Checked %0d triangle words; %0d of them closed a mesh.",
             triangles_checked, meshes_closed);
    if (mismatches == 0 && expected_tris.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
